FILE: hdl/dct8l_pkg.sv
// Package for the eight-point Loeffler DCT row transform.
// Holds widths, register indexes, reset values, payload structs and rounding helpers.
// No dependencies; used by dct8l_cfg and dct8_loeffler_1d.
package dct8l_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int FRAC_BITS     = 14;
  localparam int COEF_WIDTH    = 20;
  localparam int K_WIDTH       = 16;
  localparam int NUM_REGS      = 7;
  localparam int CFG_IDX_WIDTH = $clog2(NUM_REGS);

  // Datapath widths, each just wide enough for the values it holds.
  localparam int BF_W   = SAMPLE_WIDTH + 1;
  localparam int EV_W   = SAMPLE_WIDTH + 2;
  localparam int DC_W   = SAMPLE_WIDTH + 3;
  localparam int OP_W   = BF_W + K_WIDTH;
  localparam int ROT_W  = OP_W + 1;
  localparam int OSUM_W = ROT_W + 2;
  localparam int ODIF_W = ROT_W + 1;
  localparam int EP_W   = EV_W + K_WIDTH;
  localparam int ESUM_W = EP_W + 1;
  localparam int RND_W  = ODIF_W + 1 - FRAC_BITS;
  localparam int SC_W   = RND_W + K_WIDTH;
  localparam int ACC_W  = ((OSUM_W > SC_W) ? OSUM_W : SC_W) + 1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [K_WIDTH-1:0]      kval_t;
  typedef logic signed [ACC_W-1:0]        acc_t;
  typedef logic [CFG_IDX_WIDTH-1:0]       cfg_idx_t;

  localparam cfg_idx_t CFG_EVEN_ROT_COS = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_EVEN_ROT_SIN = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_ODD3_COS     = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_ODD3_SIN     = cfg_idx_t'(3);
  localparam cfg_idx_t CFG_ODD1_COS     = cfg_idx_t'(4);
  localparam cfg_idx_t CFG_ODD1_SIN     = cfg_idx_t'(5);
  localparam cfg_idx_t CFG_ROOT_TWO     = cfg_idx_t'(6);

  typedef struct packed {
    sample_t sample_0;
    sample_t sample_1;
    sample_t sample_2;
    sample_t sample_3;
    sample_t sample_4;
    sample_t sample_5;
    sample_t sample_6;
    sample_t sample_7;
  } sample_row_t;

  typedef struct packed {
    coef_t coef_0;
    coef_t coef_1;
    coef_t coef_2;
    coef_t coef_3;
    coef_t coef_4;
    coef_t coef_5;
    coef_t coef_6;
    coef_t coef_7;
  } coef_row_t;

  typedef struct packed {
    kval_t even_rot_cos;
    kval_t even_rot_sin;
    kval_t odd3_cos;
    kval_t odd3_sin;
    kval_t odd1_cos;
    kval_t odd1_sin;
    kval_t root_two;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    even_rot_cos: kval_t'(8867),
    even_rot_sin: kval_t'(21407),
    odd3_cos:     kval_t'(13623),
    odd3_sin:     kval_t'(9102),
    odd1_cos:     kval_t'(16069),
    odd1_sin:     kval_t'(3196),
    root_two:     kval_t'(23170)
  };

  localparam acc_t ACC_HALF = acc_t'(2 ** (FRAC_BITS - 1));
  localparam acc_t ACC_MAX  = acc_t'(2 ** (COEF_WIDTH - 1) - 1);
  localparam acc_t ACC_MIN  = acc_t'(-(2 ** (COEF_WIDTH - 1)));

  // Adds one half and floors, so ties round toward plus infinity.
  function automatic acc_t round_acc(input acc_t x);
    acc_t sum;
    sum = x + ACC_HALF;
    return sum >>> FRAC_BITS;
  endfunction

  function automatic coef_t sat_coef(input acc_t x);
    acc_t clamped;
    if (x > ACC_MAX) begin
      clamped = ACC_MAX;
    end else if (x < ACC_MIN) begin
      clamped = ACC_MIN;
    end else begin
      clamped = x;
    end
    return clamped[COEF_WIDTH-1:0];
  endfunction

endpackage

FILE: hdl/dct8l_cfg.sv
// Rotation and scale factor registers of the eight-point DCT.
// Plain write port, indexes beyond the last register are ignored.
// Depends on dct8l_pkg.
module dct8l_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  dct8l_pkg::cfg_idx_t cfg_idx_i,
  input  dct8l_pkg::kval_t    cfg_wdata_i,
  output dct8l_pkg::cfg_t     cfg_o
);

  dct8l_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dct8l_pkg::CFG_EVEN_ROT_COS: cfg_d.even_rot_cos = cfg_wdata_i;
        dct8l_pkg::CFG_EVEN_ROT_SIN: cfg_d.even_rot_sin = cfg_wdata_i;
        dct8l_pkg::CFG_ODD3_COS:     cfg_d.odd3_cos     = cfg_wdata_i;
        dct8l_pkg::CFG_ODD3_SIN:     cfg_d.odd3_sin     = cfg_wdata_i;
        dct8l_pkg::CFG_ODD1_COS:     cfg_d.odd1_cos     = cfg_wdata_i;
        dct8l_pkg::CFG_ODD1_SIN:     cfg_d.odd1_sin     = cfg_wdata_i;
        dct8l_pkg::CFG_ROOT_TWO:     cfg_d.root_two     = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= dct8l_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/dct8_loeffler_1d.sv
// Top level of the eight-point Loeffler DCT row transform.
// Seven-stage pipeline of butterflies, rotations, rounding and saturation.
// Depends on dct8l_pkg and dct8l_cfg.
//
// Usage:
//   A row of eight signed samples enters on the in_valid_i / in_ready_o
//   channel; one transaction carries the whole row. All eight saturated
//   coefficients leave together on the out_valid_o / out_ready_i channel.
//   The seven factor registers are written through cfg_we_i, cfg_idx_i and
//   cfg_wdata_i; the user must write them only while no row is in flight,
//   as the block does not enforce it. Output valid rises once a row has
//   passed the seven register stages: butterflies, products, rotation sums,
//   output sums, first rounding, the root-two multiply and the final
//   rounding. One row can enter every cycle while the receiver does not
//   stall the output.
//   Each stage has its own valid bit and moves when its successor has room,
//   so a stalled receiver holds the output register and the stages behind it
//   fill up before in_ready_o drops; nothing is lost or repeated.
//   Reset empties the pipeline and loads the factor defaults.
module dct8_loeffler_1d (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  dct8l_pkg::sample_row_t in_row_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output dct8l_pkg::coef_row_t   out_row_o,
  input  logic                   cfg_we_i,
  input  dct8l_pkg::cfg_idx_t    cfg_idx_i,
  input  dct8l_pkg::kval_t       cfg_wdata_i
);

  localparam int NumStages = 7;

  dct8l_pkg::cfg_t cfg;

  dct8l_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // Handshake: per-stage valid bits with a ready chain.
  logic [NumStages:1] vld_q;
  logic [NumStages:1] vld_in;
  logic [NumStages:1] adv;
  logic [NumStages:1] load;

  assign vld_in = {vld_q[NumStages-1:1], in_valid_i};

  always_comb begin
    adv[NumStages] = !vld_q[NumStages] || out_ready_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign load       = adv & vld_in;
  assign in_ready_o = adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  // Stage 1: butterflies.
  dct8l_pkg::sample_t xs [8];
  logic signed [dct8l_pkg::BF_W-1:0] p_q [4];
  logic signed [dct8l_pkg::BF_W-1:0] n_q [4];

  assign xs[0] = in_row_i.sample_0;
  assign xs[1] = in_row_i.sample_1;
  assign xs[2] = in_row_i.sample_2;
  assign xs[3] = in_row_i.sample_3;
  assign xs[4] = in_row_i.sample_4;
  assign xs[5] = in_row_i.sample_5;
  assign xs[6] = in_row_i.sample_6;
  assign xs[7] = in_row_i.sample_7;

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      for (int i = 0; i < 4; i++) begin
        p_q[i] <= dct8l_pkg::BF_W'(xs[i]) + dct8l_pkg::BF_W'(xs[7-i]);
        n_q[i] <= dct8l_pkg::BF_W'(xs[i]) - dct8l_pkg::BF_W'(xs[7-i]);
      end
    end
  end

  // Stage 2: odd-part products, even differences, coefficients zero and four.
  logic signed [dct8l_pkg::OP_W-1:0] op_q [8];
  logic signed [dct8l_pkg::EV_W-1:0] e12_q, e03_q;
  logic signed [dct8l_pkg::DC_W-1:0] dc_q2, ac4_q2;

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      op_q[0] <= dct8l_pkg::OP_W'(n_q[0]) * dct8l_pkg::OP_W'(cfg.odd3_cos);
      op_q[1] <= dct8l_pkg::OP_W'(n_q[3]) * dct8l_pkg::OP_W'(cfg.odd3_sin);
      op_q[2] <= dct8l_pkg::OP_W'(n_q[2]) * dct8l_pkg::OP_W'(cfg.odd1_cos);
      op_q[3] <= dct8l_pkg::OP_W'(n_q[1]) * dct8l_pkg::OP_W'(cfg.odd1_sin);
      op_q[4] <= dct8l_pkg::OP_W'(n_q[3]) * dct8l_pkg::OP_W'(cfg.odd3_cos);
      op_q[5] <= dct8l_pkg::OP_W'(n_q[0]) * dct8l_pkg::OP_W'(cfg.odd3_sin);
      op_q[6] <= dct8l_pkg::OP_W'(n_q[1]) * dct8l_pkg::OP_W'(cfg.odd1_cos);
      op_q[7] <= dct8l_pkg::OP_W'(n_q[2]) * dct8l_pkg::OP_W'(cfg.odd1_sin);
      e12_q   <= dct8l_pkg::EV_W'(p_q[1]) - dct8l_pkg::EV_W'(p_q[2]);
      e03_q   <= dct8l_pkg::EV_W'(p_q[0]) - dct8l_pkg::EV_W'(p_q[3]);
      dc_q2   <= dct8l_pkg::DC_W'(p_q[0]) + dct8l_pkg::DC_W'(p_q[1])
               + dct8l_pkg::DC_W'(p_q[2]) + dct8l_pkg::DC_W'(p_q[3]);
      ac4_q2  <= dct8l_pkg::DC_W'(p_q[0]) - dct8l_pkg::DC_W'(p_q[1])
               - dct8l_pkg::DC_W'(p_q[2]) + dct8l_pkg::DC_W'(p_q[3]);
    end
  end

  // Stage 3: odd rotation outputs and even products.
  logic signed [dct8l_pkg::ROT_W-1:0] ta_q, tb_q, tc_q, td_q;
  logic signed [dct8l_pkg::EP_W-1:0]  ep_q [4];
  logic signed [dct8l_pkg::DC_W-1:0]  dc_q3, ac4_q3;

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      ta_q    <= dct8l_pkg::ROT_W'(op_q[0]) - dct8l_pkg::ROT_W'(op_q[1]);
      tb_q    <= dct8l_pkg::ROT_W'(op_q[2]) + dct8l_pkg::ROT_W'(op_q[3]);
      tc_q    <= dct8l_pkg::ROT_W'(op_q[4]) + dct8l_pkg::ROT_W'(op_q[5]);
      td_q    <= dct8l_pkg::ROT_W'(op_q[6]) - dct8l_pkg::ROT_W'(op_q[7]);
      ep_q[0] <= dct8l_pkg::EP_W'(e12_q) * dct8l_pkg::EP_W'(cfg.even_rot_cos);
      ep_q[1] <= dct8l_pkg::EP_W'(e03_q) * dct8l_pkg::EP_W'(cfg.even_rot_sin);
      ep_q[2] <= dct8l_pkg::EP_W'(e12_q) * dct8l_pkg::EP_W'(cfg.even_rot_sin);
      ep_q[3] <= dct8l_pkg::EP_W'(e03_q) * dct8l_pkg::EP_W'(cfg.even_rot_cos);
      dc_q3   <= dc_q2;
      ac4_q3  <= ac4_q2;
    end
  end

  // Stage 4: output sums before rounding.
  logic signed [dct8l_pkg::OSUM_W-1:0] s1_q, s7_q;
  logic signed [dct8l_pkg::ODIF_W-1:0] d3_q, d5_q;
  logic signed [dct8l_pkg::ESUM_W-1:0] c2s_q, c6s_q;
  logic signed [dct8l_pkg::DC_W-1:0]   dc_q4, ac4_q4;

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      s1_q   <= dct8l_pkg::OSUM_W'(ta_q) + dct8l_pkg::OSUM_W'(tb_q)
              + dct8l_pkg::OSUM_W'(tc_q) + dct8l_pkg::OSUM_W'(td_q);
      s7_q   <= dct8l_pkg::OSUM_W'(ta_q) + dct8l_pkg::OSUM_W'(tb_q)
              - dct8l_pkg::OSUM_W'(tc_q) - dct8l_pkg::OSUM_W'(td_q);
      d3_q   <= dct8l_pkg::ODIF_W'(ta_q) - dct8l_pkg::ODIF_W'(tb_q);
      d5_q   <= dct8l_pkg::ODIF_W'(tc_q) - dct8l_pkg::ODIF_W'(td_q);
      c2s_q  <= dct8l_pkg::ESUM_W'(ep_q[0]) + dct8l_pkg::ESUM_W'(ep_q[1]);
      c6s_q  <= dct8l_pkg::ESUM_W'(ep_q[3]) - dct8l_pkg::ESUM_W'(ep_q[2]);
      dc_q4  <= dc_q3;
      ac4_q4 <= ac4_q3;
    end
  end

  // Stage 5: rounding and saturation; coefficients three and five round once here.
  logic signed [dct8l_pkg::RND_W-1:0] r3_q, r5_q;
  dct8l_pkg::coef_t c0_q5, c1_q5, c2_q5, c4_q5, c6_q5, c7_q5;

  always_ff @(posedge clk_i) begin
    if (load[5]) begin
      r3_q  <= dct8l_pkg::RND_W'(dct8l_pkg::round_acc(dct8l_pkg::acc_t'(d3_q)));
      r5_q  <= dct8l_pkg::RND_W'(dct8l_pkg::round_acc(dct8l_pkg::acc_t'(d5_q)));
      c0_q5 <= dct8l_pkg::sat_coef(dct8l_pkg::acc_t'(dc_q4));
      c4_q5 <= dct8l_pkg::sat_coef(dct8l_pkg::acc_t'(ac4_q4));
      c1_q5 <= dct8l_pkg::sat_coef(dct8l_pkg::round_acc(dct8l_pkg::acc_t'(s1_q)));
      c7_q5 <= dct8l_pkg::sat_coef(dct8l_pkg::round_acc(dct8l_pkg::acc_t'(s7_q)));
      c2_q5 <= dct8l_pkg::sat_coef(dct8l_pkg::round_acc(dct8l_pkg::acc_t'(c2s_q)));
      c6_q5 <= dct8l_pkg::sat_coef(dct8l_pkg::round_acc(dct8l_pkg::acc_t'(c6s_q)));
    end
  end

  // Stage 6: root-two scaling of coefficients three and five.
  logic signed [dct8l_pkg::SC_W-1:0] m3_q, m5_q;
  dct8l_pkg::coef_t c0_q6, c1_q6, c2_q6, c4_q6, c6_q6, c7_q6;

  always_ff @(posedge clk_i) begin
    if (load[6]) begin
      m3_q  <= dct8l_pkg::SC_W'(r3_q) * dct8l_pkg::SC_W'(cfg.root_two);
      m5_q  <= dct8l_pkg::SC_W'(r5_q) * dct8l_pkg::SC_W'(cfg.root_two);
      c0_q6 <= c0_q5;
      c1_q6 <= c1_q5;
      c2_q6 <= c2_q5;
      c4_q6 <= c4_q5;
      c6_q6 <= c6_q5;
      c7_q6 <= c7_q5;
    end
  end

  // Stage 7: output register.
  dct8l_pkg::coef_row_t out_q;

  always_ff @(posedge clk_i) begin
    if (load[7]) begin
      out_q.coef_0 <= c0_q6;
      out_q.coef_1 <= c1_q6;
      out_q.coef_2 <= c2_q6;
      out_q.coef_3 <= dct8l_pkg::sat_coef(dct8l_pkg::round_acc(dct8l_pkg::acc_t'(m3_q)));
      out_q.coef_4 <= c4_q6;
      out_q.coef_5 <= dct8l_pkg::sat_coef(dct8l_pkg::round_acc(dct8l_pkg::acc_t'(m5_q)));
      out_q.coef_6 <= c6_q6;
      out_q.coef_7 <= c7_q6;
    end
  end

  assign out_valid_o = vld_q[NumStages];
  assign out_row_o   = out_q;

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the eight-point Loeffler DCT row transform.
// Drives sample rows over valid/ready, predicts each coefficient row in plain
// integer arithmetic and checks results in order. Depends on dct8l_pkg.
`timescale 1ns / 100ps

module testbench;

  localparam int ROWS_PER_PHASE = 75;
  localparam int NUM_PHASES     = 6;
  localparam int DRAIN_CYCLES   = 12;
  localparam int STALL_LIMIT    = 5000;
  localparam int MAX_REPORTS    = 40;

  localparam dct8l_pkg::sample_t SMAX = {1'b0, {(dct8l_pkg::SAMPLE_WIDTH-1){1'b1}}};
  localparam dct8l_pkg::sample_t SMIN = {1'b1, {(dct8l_pkg::SAMPLE_WIDTH-1){1'b0}}};
  localparam dct8l_pkg::kval_t   KMAX = {1'b0, {(dct8l_pkg::K_WIDTH-1){1'b1}}};
  localparam dct8l_pkg::kval_t   KMIN = {1'b1, {(dct8l_pkg::K_WIDTH-1){1'b0}}};

  localparam longint COEF_HI = (longint'(1) <<< (dct8l_pkg::COEF_WIDTH - 1)) - 1;
  localparam longint COEF_LO = -(longint'(1) <<< (dct8l_pkg::COEF_WIDTH - 1));

  localparam dct8l_pkg::cfg_idx_t CFG_IDX_SPARE = dct8l_pkg::cfg_idx_t'(dct8l_pkg::NUM_REGS);
  localparam dct8l_pkg::cfg_idx_t FACTOR_REGS [dct8l_pkg::NUM_REGS+1] = '{
    dct8l_pkg::CFG_EVEN_ROT_COS, dct8l_pkg::CFG_EVEN_ROT_SIN, dct8l_pkg::CFG_ODD3_COS,
    dct8l_pkg::CFG_ODD3_SIN, dct8l_pkg::CFG_ODD1_COS, dct8l_pkg::CFG_ODD1_SIN,
    dct8l_pkg::CFG_ROOT_TWO, CFG_IDX_SPARE
  };

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  dct8l_pkg::sample_row_t in_row    = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  dct8l_pkg::coef_row_t   out_row;
  logic                   cfg_we    = 1'b0;
  dct8l_pkg::cfg_idx_t    cfg_idx   = dct8l_pkg::CFG_EVEN_ROT_COS;
  dct8l_pkg::kval_t       cfg_wdata = '0;

  dct8l_pkg::cfg_t        factors = dct8l_pkg::CFG_RESET;
  dct8l_pkg::sample_row_t pending_rows [$];
  dct8l_pkg::coef_row_t   expected_coefs [$];
  int                     sender_idle_pct = 0;
  int                     sink_stall_pct  = 0;
  int                     error_count     = 0;
  int                     rows_sent       = 0;
  int                     rows_checked    = 0;
  int                     quiet_cycles    = 0;

  dct8_loeffler_1d i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_row_i    (in_row),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_row_o   (out_row),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint round_q(input longint v);
    return (v + (longint'(1) <<< (dct8l_pkg::FRAC_BITS - 1))) >>> dct8l_pkg::FRAC_BITS;
  endfunction

  function automatic dct8l_pkg::coef_t clamp_coef(input longint v);
    if (v > COEF_HI) begin
      return dct8l_pkg::coef_t'(COEF_HI);
    end else if (v < COEF_LO) begin
      return dct8l_pkg::coef_t'(COEF_LO);
    end
    return dct8l_pkg::coef_t'(v);
  endfunction

  function automatic dct8l_pkg::coef_row_t dct_row(input dct8l_pkg::sample_row_t row,
                                                   input dct8l_pkg::cfg_t k);
    longint x [8];
    longint p0, p1, p2, p3, n0, n1, n2, n3;
    longint ta, tb, tc, td;
    dct8l_pkg::coef_row_t r;
    x[0] = row.sample_0;
    x[1] = row.sample_1;
    x[2] = row.sample_2;
    x[3] = row.sample_3;
    x[4] = row.sample_4;
    x[5] = row.sample_5;
    x[6] = row.sample_6;
    x[7] = row.sample_7;
    p0 = x[0] + x[7];
    p1 = x[1] + x[6];
    p2 = x[2] + x[5];
    p3 = x[3] + x[4];
    n0 = x[0] - x[7];
    n1 = x[1] - x[6];
    n2 = x[2] - x[5];
    n3 = x[3] - x[4];
    ta = n0 * longint'(k.odd3_cos) - n3 * longint'(k.odd3_sin);
    tb = n2 * longint'(k.odd1_cos) + n1 * longint'(k.odd1_sin);
    tc = n3 * longint'(k.odd3_cos) + n0 * longint'(k.odd3_sin);
    td = n1 * longint'(k.odd1_cos) - n2 * longint'(k.odd1_sin);
    r.coef_0 = clamp_coef(p0 + p1 + p2 + p3);
    r.coef_1 = clamp_coef(round_q(ta + tb + tc + td));
    r.coef_2 = clamp_coef(round_q((p1 - p2) * longint'(k.even_rot_cos)
                                  + (p0 - p3) * longint'(k.even_rot_sin)));
    r.coef_3 = clamp_coef(round_q(longint'(k.root_two) * round_q(ta - tb)));
    r.coef_4 = clamp_coef(p0 - p1 - p2 + p3);
    r.coef_5 = clamp_coef(round_q(longint'(k.root_two) * round_q(tc - td)));
    r.coef_6 = clamp_coef(round_q((p2 - p1) * longint'(k.even_rot_sin)
                                  + (p0 - p3) * longint'(k.even_rot_cos)));
    r.coef_7 = clamp_coef(round_q((ta + tb) - (tc + td)));
    return r;
  endfunction

  function automatic dct8l_pkg::sample_row_t random_row();
    dct8l_pkg::sample_row_t r;
    dct8l_pkg::sample_t s;
    int unsigned style;
    style = $urandom_range(9);
    for (int i = 0; i < 8; i++) begin
      if (style < 6) begin
        s = dct8l_pkg::sample_t'($urandom);
      end else if (style < 8) begin
        case ($urandom_range(4))
          0: s = SMAX;
          1: s = SMIN;
          2: s = '0;
          3: s = dct8l_pkg::sample_t'(1);
          default: s = dct8l_pkg::sample_t'(-1);
        endcase
      end else begin
        s = dct8l_pkg::sample_t'(int'($urandom_range(32)) - 16);
      end
      r[i*dct8l_pkg::SAMPLE_WIDTH +: dct8l_pkg::SAMPLE_WIDTH] = s;
    end
    return r;
  endfunction

  function automatic dct8l_pkg::kval_t random_factor(input bit with_extremes);
    if (with_extremes) begin
      case ($urandom_range(4))
        0: return KMAX;
        1: return KMIN;
        2: return '0;
        default: ;
      endcase
    end
    return dct8l_pkg::kval_t'($urandom);
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // The spare index is written last with random data and must change nothing.
  task automatic load_factors(input dct8l_pkg::kval_t vals [dct8l_pkg::NUM_REGS]);
    dct8l_pkg::kval_t v;
    for (int i = 0; i <= dct8l_pkg::NUM_REGS; i++) begin
      v = (i < dct8l_pkg::NUM_REGS) ? vals[i] : dct8l_pkg::kval_t'($urandom);
      @(posedge clk_i);
      cfg_we    <= 1'b1;
      cfg_idx   <= FACTOR_REGS[i];
      cfg_wdata <= v;
      case (FACTOR_REGS[i])
        dct8l_pkg::CFG_EVEN_ROT_COS: factors.even_rot_cos = v;
        dct8l_pkg::CFG_EVEN_ROT_SIN: factors.even_rot_sin = v;
        dct8l_pkg::CFG_ODD3_COS:     factors.odd3_cos     = v;
        dct8l_pkg::CFG_ODD3_SIN:     factors.odd3_sin     = v;
        dct8l_pkg::CFG_ODD1_COS:     factors.odd1_cos     = v;
        dct8l_pkg::CFG_ODD1_SIN:     factors.odd1_sin     = v;
        dct8l_pkg::CFG_ROOT_TWO:     factors.root_two     = v;
        default: ;
      endcase
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_row   <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_coefs.push_back(dct_row(in_row, factors));
        rows_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_rows.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_row   <= pending_rows.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    dct8l_pkg::coef_row_t want;
    logic signed [dct8l_pkg::COEF_WIDTH-1:0] got_c, want_c;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        rows_checked++;
        if (expected_coefs.size() == 0) begin
          report_mismatch($sformatf("result row %0d with nothing expected", rows_checked));
        end else begin
          want = expected_coefs.pop_front();
          for (int f = 0; f < 8; f++) begin
            got_c  = out_row[(7-f)*dct8l_pkg::COEF_WIDTH +: dct8l_pkg::COEF_WIDTH];
            want_c = want[(7-f)*dct8l_pkg::COEF_WIDTH +: dct8l_pkg::COEF_WIDTH];
            if (got_c !== want_c) begin
              report_mismatch($sformatf("row %0d coef_%0d: got %0d, expected %0d",
                                        rows_checked, f, got_c, want_c));
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    dct8l_pkg::kval_t vals [dct8l_pkg::NUM_REGS];
    dct8l_pkg::sample_row_t row;
    dct8l_pkg::cfg_t defaults;
    defaults = dct8l_pkg::CFG_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      @(negedge clk_i);
      sender_idle_pct = (phase < 2) ? 11 : (phase < 4) ? 46 : 0;
      sink_stall_pct  = (phase < 2) ? 46 : (phase < 4) ? 11 : 0;
      if (phase != 0) begin
        for (int i = 0; i < dct8l_pkg::NUM_REGS; i++) begin
          case (phase)
            1: vals[i] = KMAX;
            2: vals[i] = KMIN;
            3: vals[i] = random_factor(1'b0);
            4: vals[i] = random_factor(1'b1);
            default: ;
          endcase
        end
        if (phase == NUM_PHASES - 1) begin
          vals = '{defaults.even_rot_cos, defaults.even_rot_sin, defaults.odd3_cos,
                   defaults.odd3_sin, defaults.odd1_cos, defaults.odd1_sin,
                   defaults.root_two};
        end
        load_factors(vals);
        @(negedge clk_i);
      end else begin
        pending_rows.push_back('0);
        pending_rows.push_back({8{SMAX}});
        pending_rows.push_back({8{SMIN}});
        pending_rows.push_back({8{dct8l_pkg::sample_t'(-1)}});
        pending_rows.push_back({4{SMAX, SMIN}});
        pending_rows.push_back({{4{SMAX}}, {4{SMIN}}});
        pending_rows.push_back({{2{SMAX}}, {4{SMIN}}, {2{SMAX}}});
        pending_rows.push_back({SMAX, {2{SMIN}}, {2{SMAX}}, {2{SMIN}}, SMAX});
        pending_rows.push_back({SMAX, SMIN, SMAX, SMIN, SMIN, SMAX, SMIN, SMAX});
        pending_rows.push_back({4{dct8l_pkg::sample_t'(1), dct8l_pkg::sample_t'(-1)}});
        for (int i = 0; i < 8; i++) begin
          row = '0;
          row[i*dct8l_pkg::SAMPLE_WIDTH +: dct8l_pkg::SAMPLE_WIDTH] = SMAX;
          pending_rows.push_back(row);
        end
      end
      repeat (ROWS_PER_PHASE) pending_rows.push_back(random_row());
      do @(negedge clk_i);
      while (pending_rows.size() != 0 || in_valid || expected_coefs.size() != 0);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d rows sent, %0d result rows checked", rows_sent, rows_checked);
    $display("factors: defaults, all max, all min, random, mixed extremes, defaults");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
